FILE: design/teq_pkg.sv
`default_nettype none

package teq_pkg;

  localparam int TEQ_DEPTH  = 16;
  localparam int TIME_W     = 32;
  localparam int ID_W       = 16;
  localparam int ACT_W      = 3;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LIST    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST_AT = 3'd4;

  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LISTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PAST   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] time_value;
    logic [ID_W-1:0]   event_id;
  } teq_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     out_event_id;
    logic [TIME_W-1:0]   out_event_time;
    logic [STATUS_W-1:0] status;
    logic                last;
  } teq_out_t;

  // What every cell of the chain does at a clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_ROTATE
  } teq_cell_op_t;

  typedef struct packed {
    teq_cell_op_t      op;
    logic              match_en;
    logic [TIME_W-1:0] key_time;
    logic [ID_W-1:0]   key_id;
  } teq_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/teq_cell.sv
`default_nettype none

module teq_cell (
  input  wire                          clk,
  input  wire  teq_pkg::teq_cell_ctrl_t ctrl,
  input  wire                          self_valid,
  input  wire  [teq_pkg::TIME_W-1:0]   head_time,
  input  wire  [teq_pkg::ID_W-1:0]     head_id,
  input  wire  [teq_pkg::TIME_W-1:0]   left_time,
  input  wire  [teq_pkg::ID_W-1:0]     left_id,
  input  wire                          left_shift,
  input  wire  [teq_pkg::TIME_W-1:0]   right_time,
  input  wire  [teq_pkg::ID_W-1:0]     right_id,
  input  wire                          right_valid,
  input  wire                          kill_in,
  output logic [teq_pkg::TIME_W-1:0]   cell_time,
  output logic [teq_pkg::ID_W-1:0]     cell_id,
  output logic                         shift_out,
  output logic                         kill_out
);
  import teq_pkg::*;

  logic [TIME_W-1:0] time_r, time_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  assign cell_time = time_r;
  assign cell_id   = id_r;

  // An empty cell or one holding a later time moves one place toward the tail
  // on insert, so a new event lands after every event with the same time.
  assign shift_out = !self_valid || (time_r > ctrl.key_time);

  // Once a cell drops out, every cell behind it closes the gap.
  assign kill_out = kill_in || (ctrl.match_en && self_valid && (time_r == ctrl.key_time));

  always_comb begin
    time_nxt = time_r;
    id_nxt   = id_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (shift_out) begin
          if (left_shift) begin
            time_nxt = left_time;
            id_nxt   = left_id;
          end else begin
            time_nxt = ctrl.key_time;
            id_nxt   = ctrl.key_id;
          end
        end
      end
      CELL_SHIFT: begin
        if (kill_out) begin
          time_nxt = right_time;
          id_nxt   = right_id;
        end
      end
      CELL_ROTATE: begin
        if (self_valid) begin
          if (right_valid) begin
            time_nxt = right_time;
            id_nxt   = right_id;
          end else begin
            time_nxt = head_time;
            id_nxt   = head_id;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    id_r   <= id_nxt;
  end

endmodule

`default_nettype wire

FILE: design/timed_event_queue.sv
`default_nettype none
// Add and undefined actions strobe their status beat in the cycle after start. Advance,
// remove and the list actions handle one fired, removed or visited entry per cycle and
// then send the closing status beat. Adds can follow every cycle; other actions keep
// busy high until their closing status beat. Reset (rst_n low, synchronous) empties the
// queue and zeroes the current time. Results are strobed on out_valid; the receiver
// cannot stall.

module timed_event_queue #(
  parameter int QUEUE_DEPTH = teq_pkg::TEQ_DEPTH
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  teq_pkg::teq_in_t  in_data,
  output logic              out_valid,
  output teq_pkg::teq_out_t out_data
);
  import teq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADVANCE,
    S_REMOVE,
    S_LIST
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  visit_r;
  logic [TIME_W-1:0] cur_time_r;
  logic [TIME_W-1:0] key_time_r;
  logic              list_all_r;
  logic              out_valid_r;
  teq_out_t          out_r;
  logic              out_valid_nxt;
  teq_out_t          out_nxt;

  teq_cell_ctrl_t    ctrl;

  // Chain wiring. Cell 0 is the head and holds the earliest event.
  logic [TIME_W-1:0] cell_time [QUEUE_DEPTH];
  logic [ID_W-1:0]   cell_id   [QUEUE_DEPTH];
  logic              cell_valid [QUEUE_DEPTH];
  logic              shift_c [QUEUE_DEPTH];
  logic              kill_c  [QUEUE_DEPTH+1];

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Occupied cells are always a prefix of the chain, so the fill count alone
  // tells which cells hold events.
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic [TIME_W-1:0] lt, rt;
      logic [ID_W-1:0]   lid, rid;
      logic              lsh, rv;

      assign cell_valid[gi] = (count_r > CNT_W'(gi));

      if (gi == 0) begin : g_left_end
        assign lt  = '0;
        assign lid = '0;
        assign lsh = 1'b0;
      end else begin : g_left
        assign lt  = cell_time[gi-1];
        assign lid = cell_id[gi-1];
        assign lsh = shift_c[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_right_end
        assign rt  = '0;
        assign rid = '0;
        assign rv  = 1'b0;
      end else begin : g_right
        assign rt  = cell_time[gi+1];
        assign rid = cell_id[gi+1];
        assign rv  = cell_valid[gi+1];
      end

      teq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .self_valid  (cell_valid[gi]),
        .head_time   (cell_time[0]),
        .head_id     (cell_id[0]),
        .left_time   (lt),
        .left_id     (lid),
        .left_shift  (lsh),
        .right_time  (rt),
        .right_id    (rid),
        .right_valid (rv),
        .kill_in     (kill_c[gi]),
        .cell_time   (cell_time[gi]),
        .cell_id     (cell_id[gi]),
        .shift_out   (shift_c[gi]),
        .kill_out    (kill_c[gi+1])
      );
    end
  endgenerate

  // With matching off, the head is dropped and every cell moves up one place.
  // With matching on, the first cell whose time equals the key is dropped.
  assign kill_c[0] = !ctrl.match_en;

  logic              accept;
  logic              queue_full;
  logic              add_past;
  logic              head_due;
  logic              any_match;
  logic [TIME_W:0]   adv_sum;
  logic [TIME_W-1:0] adv_time;

  assign accept     = start && !busy;
  assign queue_full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign add_past   = (in_data.time_value <= cur_time_r);
  assign head_due   = (count_r != '0) && (cell_time[0] <= cur_time_r);
  assign any_match  = kill_c[QUEUE_DEPTH];
  assign adv_sum    = {1'b0, cur_time_r} + {1'b0, in_data.time_value};
  assign adv_time   = adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];

  // Cell command for this cycle.
  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.match_en = 1'b0;
    ctrl.key_time = key_time_r;
    ctrl.key_id   = in_data.event_id;
    case (state_r)
      S_IDLE: begin
        ctrl.key_time = in_data.time_value;
        if (accept && (in_data.action == ACT_ADD) && !add_past && !queue_full) begin
          ctrl.op = CELL_INSERT;
        end
      end
      S_ADVANCE: begin
        if (head_due) begin
          ctrl.op = CELL_SHIFT;
        end
      end
      S_REMOVE: begin
        // Matches are contiguous in a sorted chain; one leaves per cycle.
        ctrl.op       = CELL_SHIFT;
        ctrl.match_en = 1'b1;
      end
      S_LIST: begin
        if (visit_r != count_r) begin
          ctrl.op = CELL_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  // Result beat for the next cycle. Unless an event is fired or listed, the
  // beat is the closing status beat carrying the current time.
  always_comb begin
    out_valid_nxt          = 1'b0;
    out_nxt.kind           = KIND_STATUS;
    out_nxt.out_event_id   = '0;
    out_nxt.out_event_time = cur_time_r;
    out_nxt.status         = ST_OK;
    out_nxt.last           = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_ADD: begin
              // Status beat goes out right away; the insert happens this edge.
              out_valid_nxt = 1'b1;
              if (add_past) begin
                out_nxt.status = ST_PAST;
              end else if (queue_full) begin
                out_nxt.status = ST_FULL;
              end
            end
            ACT_REMOVE, ACT_ADVANCE, ACT_LIST, ACT_LIST_AT: begin
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ADVANCE: begin
        out_valid_nxt = 1'b1;
        if (head_due) begin
          out_nxt.kind           = KIND_FIRED;
          out_nxt.out_event_id   = cell_id[0];
          out_nxt.out_event_time = cell_time[0];
          out_nxt.last           = 1'b0;
        end
      end
      S_REMOVE: begin
        if (!any_match) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_LIST: begin
        if (visit_r != count_r) begin
          // The head is read out, then the chain rotates by one place.
          if (list_all_r || (cell_time[0] == key_time_r)) begin
            out_valid_nxt          = 1'b1;
            out_nxt.kind           = KIND_LISTED;
            out_nxt.out_event_id   = cell_id[0];
            out_nxt.out_event_time = cell_time[0];
            out_nxt.last           = 1'b0;
          end
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      visit_r     <= '0;
      cur_time_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_time_r <= in_data.time_value;
            visit_r    <= '0;
            case (in_data.action)
              ACT_ADD: begin
                if (!add_past && !queue_full) begin
                  count_r <= count_r + CNT_W'(1);
                end
              end
              ACT_REMOVE: begin
                state_r <= S_REMOVE;
              end
              ACT_ADVANCE: begin
                cur_time_r <= adv_time;
                state_r    <= S_ADVANCE;
              end
              ACT_LIST: begin
                list_all_r <= 1'b1;
                state_r    <= S_LIST;
              end
              ACT_LIST_AT: begin
                list_all_r <= 1'b0;
                state_r    <= S_LIST;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADVANCE: begin
          if (head_due) begin
            count_r <= count_r - CNT_W'(1);
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_REMOVE: begin
          if (any_match) begin
            count_r <= count_r - CNT_W'(1);
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_LIST: begin
          if (visit_r != count_r) begin
            visit_r <= visit_r + CNT_W'(1);
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("event count exceeds queue depth");

  // The closing status beat leaves together with the return to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> !busy)
    else $error("status beat while still busy");

  // An add is answered by its status beat in the next cycle.
  a_add_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.action == ACT_ADD)) |=> (out_valid_r && out_r.last))
    else $error("add without status beat");

  // A full queue never grows.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && queue_full) |=> (count_r == CNT_W'(QUEUE_DEPTH)) || !$stable(cur_time_r)
      || (count_r == $past(count_r)) || ($past(in_data.action) != ACT_ADD))
    else $error("insert into full queue");

endmodule

`default_nettype wire
